// ===== src/i2c_master_byte_engine_unit_defines.svh =====
// Assertion macros shared by the I2C master byte engine RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2CM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define I2CM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/i2cm_pkg.sv =====
// Shared types and constants for the I2C master byte engine.
// No dependencies; imported by the register block, step logic and top level.
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

    // command kinds
    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_STOP  = 3'd2;
    localparam logic [2:0] KIND_WRITE = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    // sequencer phases share the kind encoding
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_STOP  = 3'd2;
    localparam logic [2:0] PH_WRITE = 3'd3;
    localparam logic [2:0] PH_READ  = 3'd4;

    // completion status
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOACK     = 3'd1;
    localparam logic [2:0] ST_LOWBEFORE = 3'd2;
    localparam logic [2:0] ST_HIGHAFTER = 3'd3;
    localparam logic [2:0] ST_REJECTED  = 3'd4;

    // register map
    localparam int         ADDR_W       = 4;
    localparam logic [1:0] REG_HALF     = 2'd0;
    localparam logic [1:0] REG_SETUP    = 2'd1;
    localparam logic [1:0] REG_POLL     = 2'd2;

    localparam logic [15:0] HALF_RESET  = 16'd5;
    localparam logic [15:0] SETUP_RESET = 16'd2;
    localparam logic [15:0] POLL_RESET  = 16'd500;

    typedef struct packed {
        logic [2:0] phase;
        logic [2:0] step;
        logic [3:0] bits;
        logic [7:0] shift;
        logic       nack;
        logic       scl;
        logic       sda;
    } seq_state_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [2:0] status;
        logic [7:0] rx;
    } result_t;

endpackage

`default_nettype wire

// ===== src/i2cm_regs.sv =====
// APB configuration registers: half period, read setup and ack poll limit.
// Depends on i2cm_pkg for the register map and reset values.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_regs
    import i2cm_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [ADDR_W-1:0]      paddr,
    input  wire logic [31:0]            pwdata,
    output logic      [31:0]            prdata,
    output logic                        pready,
    output logic      [COUNT_WIDTH-1:0] half_ticks,
    output logic      [COUNT_WIDTH-1:0] setup_ticks,
    output logic      [COUNT_WIDTH-1:0] poll_limit
);

    logic [15:0] half_reg;
    logic [15:0] setup_reg;
    logic [15:0] poll_reg;
    logic [1:0]  index;
    logic        wr_en;

    assign pready = 1'b1;
    assign index  = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg  <= HALF_RESET;
            setup_reg <= SETUP_RESET;
            poll_reg  <= POLL_RESET;
        end else if (wr_en) begin
            case (index)
                REG_HALF:  half_reg  <= pwdata[15:0];
                REG_SETUP: setup_reg <= pwdata[15:0];
                REG_POLL:  poll_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (index)
            REG_HALF:  prdata = {16'd0, half_reg};
            REG_SETUP: prdata = {16'd0, setup_reg};
            REG_POLL:  prdata = {16'd0, poll_reg};
            default:   prdata = 32'd0;
        endcase
    end

    // counters see the register masked or extended to their own width
    assign half_ticks  = COUNT_WIDTH'(half_reg);
    assign setup_ticks = COUNT_WIDTH'(setup_reg);
    assign poll_limit  = COUNT_WIDTH'(poll_reg);

endmodule

`default_nettype wire

// ===== src/i2cm_step.sv =====
// Next-state and result logic for one tick of the bit sequencer.
// Purely combinational; depends on i2cm_pkg for state and result types.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_step
    import i2cm_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  wire seq_state_t             st_i,
    input  wire logic [COUNT_WIDTH-1:0] dly_i,
    input  wire logic [COUNT_WIDTH-1:0] pol_i,
    input  wire logic [COUNT_WIDTH-1:0] half_ticks,
    input  wire logic [COUNT_WIDTH-1:0] setup_ticks,
    input  wire logic [COUNT_WIDTH-1:0] poll_limit,
    input  wire logic [2:0]             kind,
    input  wire logic [7:0]             tx_byte,
    input  wire logic                   read_nack,
    input  wire logic                   sda_in,
    output seq_state_t                  st_o,
    output logic      [COUNT_WIDTH-1:0] dly_o,
    output logic      [COUNT_WIDTH-1:0] pol_o,
    output result_t                     res_o
);

    seq_state_t             nx;
    logic [COUNT_WIDTH-1:0] dly;
    logic [COUNT_WIDTH-1:0] pol;
    logic                   is_cmd;
    logic                   do_step;
    logic                   rej;
    logic                   fin;
    logic [2:0]             fin_st;
    logic [7:0]             fin_rx;

    always_comb begin
        nx      = st_i;
        dly     = dly_i;
        pol     = pol_i;
        is_cmd  = kind inside {[KIND_START:KIND_READ]};
        do_step = 1'b0;
        rej     = 1'b0;
        fin     = 1'b0;
        fin_st  = ST_OK;
        fin_rx  = 8'd0;

        if (st_i.phase == PH_IDLE) begin
            if (is_cmd) begin
                nx.phase = kind;
                nx.step  = 3'd0;
                nx.bits  = 4'd0;
                dly      = '0;
                pol      = '0;
                case (kind)
                    KIND_WRITE: begin
                        nx.shift = tx_byte;
                        nx.nack  = 1'b0;
                    end
                    KIND_READ: begin
                        nx.shift = 8'd0;
                        nx.nack  = read_nack;
                    end
                    default: nx.nack = 1'b0;
                endcase
                do_step = 1'b1;
            end
        end else begin
            rej = is_cmd;
            if (dly_i != '0) begin
                dly = dly_i - 1'b1;
            end else begin
                do_step = 1'b1;
            end
        end

        if (do_step) begin
            case (nx.phase)
                PH_START: begin
                    case (nx.step)
                        3'd0: begin
                            nx.sda = 1'b1; dly = half_ticks; nx.step = 3'd1;
                        end
                        3'd1: begin
                            nx.scl = 1'b1; dly = half_ticks; nx.step = 3'd2;
                        end
                        3'd2: begin
                            if (!sda_in) begin
                                fin = 1'b1; fin_st = ST_LOWBEFORE;
                            end else begin
                                nx.sda = 1'b0; dly = half_ticks; nx.step = 3'd3;
                            end
                        end
                        3'd3: begin
                            if (sda_in) begin
                                fin = 1'b1; fin_st = ST_HIGHAFTER;
                            end else begin
                                nx.scl = 1'b0; dly = half_ticks; nx.step = 3'd4;
                            end
                        end
                        default: fin = 1'b1;
                    endcase
                end
                PH_STOP: begin
                    case (nx.step)
                        3'd0: begin
                            nx.sda = 1'b0; nx.scl = 1'b0; dly = half_ticks; nx.step = 3'd1;
                        end
                        3'd1: begin
                            nx.scl = 1'b1; dly = half_ticks; nx.step = 3'd2;
                        end
                        3'd2: begin
                            nx.sda = 1'b1; dly = half_ticks; nx.step = 3'd3;
                        end
                        default: fin = 1'b1;
                    endcase
                end
                PH_WRITE: begin
                    case (nx.step)
                        3'd0: begin
                            nx.scl = 1'b0; nx.sda = nx.shift[7];
                            dly = half_ticks; nx.step = 3'd1;
                        end
                        3'd1: begin
                            nx.scl   = 1'b1;
                            dly      = half_ticks;
                            nx.shift = {nx.shift[6:0], 1'b0};
                            nx.bits  = nx.bits + 4'd1;
                            nx.step  = (nx.bits >= 4'd8) ? 3'd2 : 3'd0;
                        end
                        3'd2: begin
                            nx.scl = 1'b0; nx.sda = 1'b1; dly = half_ticks; nx.step = 3'd3;
                        end
                        3'd3: begin
                            nx.scl = 1'b1; pol = '0; nx.step = 3'd4;
                        end
                        3'd4: begin
                            if (!sda_in) begin
                                nx.scl = 1'b0; dly = half_ticks; nx.step = 3'd5;
                            end else begin
                                pol = pol + 1'b1;
                                if (pol >= poll_limit) begin
                                    nx.nack = 1'b1;
                                    nx.scl  = 1'b0; dly = half_ticks; nx.step = 3'd5;
                                end
                            end
                        end
                        default: begin
                            fin    = 1'b1;
                            fin_st = nx.nack ? ST_NOACK : ST_OK;
                        end
                    endcase
                end
                PH_READ: begin
                    case (nx.step)
                        3'd0: begin
                            nx.scl = 1'b0; nx.sda = 1'b1; dly = setup_ticks; nx.step = 3'd1;
                        end
                        3'd1: begin
                            nx.scl = 1'b1; dly = half_ticks; nx.step = 3'd2;
                        end
                        3'd2: begin
                            nx.shift = {nx.shift[6:0], sda_in};
                            nx.scl   = 1'b0;
                            dly      = half_ticks;
                            nx.bits  = nx.bits + 4'd1;
                            nx.step  = (nx.bits >= 4'd8) ? 3'd3 : 3'd1;
                        end
                        3'd3: begin
                            nx.sda = nx.nack; dly = half_ticks; nx.step = 3'd4;
                        end
                        3'd4: begin
                            nx.scl = 1'b1; dly = half_ticks; nx.step = 3'd5;
                        end
                        3'd5: begin
                            nx.scl = 1'b0; dly = half_ticks; nx.step = 3'd6;
                        end
                        default: begin
                            fin = 1'b1; fin_rx = nx.shift;
                        end
                    endcase
                end
                default: fin = 1'b1;
            endcase
        end

        if (fin) begin
            nx.phase = PH_IDLE;
            nx.step  = 3'd0;
            nx.bits  = 4'd0;
        end
    end

    assign st_o  = nx;
    assign dly_o = dly;
    assign pol_o = pol;

    assign res_o.scl    = nx.scl;
    assign res_o.sda    = nx.sda;
    assign res_o.busy   = (nx.phase != PH_IDLE);
    assign res_o.done   = fin;
    assign res_o.status = fin ? fin_st : (rej ? ST_REJECTED : ST_OK);
    assign res_o.rx     = fin ? fin_rx : 8'd0;

endmodule

`default_nettype wire

// ===== src/i2c_master_byte_engine_unit.sv =====
// Top level of the I2C master byte engine: tick input register, sequencer
// state, result register. Uses i2cm_pkg, i2cm_regs, i2cm_step and the defines header.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  s_       | in        | s_valid / s_ready  | kind, tx_byte, read_nack, sda_in
//  m_       | out       | m_valid / m_ready  | scl/sda_release, busy/done_res, status, rx
//  apb      | in        | psel/penable/pready| 3 x 16-bit registers at 0x0, 0x4, 0x8
//
// One tick request per clock cycle while m_ready keeps the result slot draining; a result
// reaches m_ through the input register, then the result register.
// The sequencer state advances only when the input register moves into the result register.
// m_ready low holds the result; s_ready stays high while the input stage can still drain.
// Synchronous active-low reset: lines released, sequencer idle, registers at defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_master_byte_engine_unit_defines.svh"

module i2c_master_byte_engine_unit
    import i2cm_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [2:0]        s_kind,
    input  wire logic [7:0]        s_tx_byte,
    input  wire logic              s_read_nack,
    input  wire logic              s_sda_in,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_scl_release,
    output logic                   m_sda_release,
    output logic                   m_busy_res,
    output logic                   m_done_res,
    output logic      [2:0]        m_status,
    output logic      [7:0]        m_rx_byte
);

    logic [COUNT_WIDTH-1:0] half_ticks;
    logic [COUNT_WIDTH-1:0] setup_ticks;
    logic [COUNT_WIDTH-1:0] poll_limit;

    logic                   in_valid_reg;
    logic [2:0]             in_kind_reg;
    logic [7:0]             in_tx_reg;
    logic                   in_nack_reg;
    logic                   in_sda_reg;

    seq_state_t             state_reg;
    seq_state_t             state_next;
    logic [COUNT_WIDTH-1:0] dly_reg;
    logic [COUNT_WIDTH-1:0] dly_next;
    logic [COUNT_WIDTH-1:0] pol_reg;
    logic [COUNT_WIDTH-1:0] pol_next;

    result_t                res_next;
    result_t                res_reg;
    logic                   out_valid_reg;
    logic                   advance;

    i2cm_regs #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .half_ticks  (half_ticks),
        .setup_ticks (setup_ticks),
        .poll_limit  (poll_limit)
    );

    i2cm_step #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_step (
        .st_i        (state_reg),
        .dly_i       (dly_reg),
        .pol_i       (pol_reg),
        .half_ticks  (half_ticks),
        .setup_ticks (setup_ticks),
        .poll_limit  (poll_limit),
        .kind        (in_kind_reg),
        .tx_byte     (in_tx_reg),
        .read_nack   (in_nack_reg),
        .sda_in      (in_sda_reg),
        .st_o        (state_next),
        .dly_o       (dly_next),
        .pol_o       (pol_next),
        .res_o       (res_next)
    );

    // a tick moves on when the result slot is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= s_kind;
            in_tx_reg   <= s_tx_byte;
            in_nack_reg <= s_read_nack;
            in_sda_reg  <= s_sda_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: PH_IDLE, step: 3'd0, bits: 4'd0, shift: 8'd0,
                           nack: 1'b0, scl: 1'b1, sda: 1'b1};
            dly_reg   <= '0;
            pol_reg   <= '0;
        end else if (advance) begin
            state_reg <= state_next;
            dly_reg   <= dly_next;
            pol_reg   <= pol_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_scl_release = res_reg.scl;
    assign m_sda_release = res_reg.sda;
    assign m_busy_res    = res_reg.busy;
    assign m_done_res    = res_reg.done;
    assign m_status      = res_reg.status;
    assign m_rx_byte     = res_reg.rx;

    `I2CM_ASSERT_NOW(a_idle_clean, aclk, aresetn, state_reg.phase == PH_IDLE,
        state_reg.step == 3'd0 && state_reg.bits == 4'd0, "idle with stale step or bit count")
    `I2CM_ASSERT_NOW(a_done_not_busy, aclk, aresetn, m_valid && m_done_res,
        !m_busy_res, "done result still reports busy")
    `I2CM_ASSERT_NOW(a_reject_busy, aclk, aresetn, m_valid && m_status == ST_REJECTED,
        m_busy_res && !m_done_res, "rejected request outside a busy command")
    `I2CM_ASSERT_NOW(a_rx_on_done, aclk, aresetn, m_valid && m_rx_byte != 8'd0,
        m_done_res, "received byte shown without done")
    `I2CM_ASSERT_NEXT(a_stall_holds_state, aclk, aresetn, in_valid_reg && !advance,
        $stable(state_reg) && in_valid_reg, "sequencer moved while result stalled")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the I2C master byte engine: directed table, then random
// command sequences against a cycle-free line model. Depends on i2cm_pkg and the DUT.
`timescale 1ns / 1ps

module tb_top;
    import i2cm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 20;
    localparam int PHASE_TICKS    = 140;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] tx;
        logic       rnack;
        logic       sda;
        bit         drain;
        bit         typed;
        result_t    want;
    } dir_row_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_valid;
    logic              s_ready;
    logic [2:0]        s_kind;
    logic [7:0]        s_tx_byte;
    logic              s_read_nack;
    logic              s_sda_in;
    logic              m_valid;
    logic              m_ready;
    logic              m_scl_release;
    logic              m_sda_release;
    logic              m_busy_res;
    logic              m_done_res;
    logic [2:0]        m_status;
    logic [7:0]        m_rx_byte;

    // line model state
    logic [15:0] cfg_half;
    logic [15:0] cfg_setup;
    logic [15:0] cfg_poll;
    logic [2:0]  eng_phase;
    logic [2:0]  eng_step;
    logic [3:0]  eng_bits;
    logic [7:0]  eng_shift;
    logic [15:0] eng_delay;
    logic [15:0] eng_poll;
    logic        eng_nack;
    logic        eng_scl;
    logic        eng_sda;
    bit          done_now;
    logic [2:0]  done_status;
    logic [7:0]  done_rx;

    result_t  pending_results[$];
    dir_row_t directed_rows[$];
    int       err_count   = 0;
    int       ticks_sent  = 0;
    int       idle_cycles = 0;
    int       gap_pct;
    int       stall_pct;

    i2c_master_byte_engine_unit DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_tx_byte    (s_tx_byte),
        .s_read_nack  (s_read_nack),
        .s_sda_in     (s_sda_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_scl_release(m_scl_release),
        .m_sda_release(m_sda_release),
        .m_busy_res   (m_busy_res),
        .m_done_res   (m_done_res),
        .m_status     (m_status),
        .m_rx_byte    (m_rx_byte)
    );

    always #5 aclk = ~aclk;

    function automatic void note_error(string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endfunction

    function automatic string fmt_result(result_t r);
        return $sformatf("scl=%0b sda=%0b busy=%0b done=%0b status=%0d rx=%02h",
                         r.scl, r.sda, r.busy, r.done, r.status, r.rx);
    endfunction

    function automatic result_t line_result(logic scl, logic sda, logic busy, logic done,
                                            logic [2:0] st);
        result_t r;
        r.scl    = scl;
        r.sda    = sda;
        r.busy   = busy;
        r.done   = done;
        r.status = st;
        r.rx     = 8'h00;
        return r;
    endfunction

    //------------------------------------------------------------------
    // Line model
    //------------------------------------------------------------------
    function automatic void end_command(logic [2:0] st, logic [7:0] rx);
        done_now    = 1'b1;
        done_status = st;
        done_rx     = rx;
        eng_phase   = PH_IDLE;
        eng_step    = 3'd0;
        eng_bits    = 4'd0;
    endfunction

    function automatic void start_step(logic sda);
        case (eng_step)
            3'd0: begin
                eng_sda = 1'b1; eng_delay = cfg_half; eng_step = 3'd1;
            end
            3'd1: begin
                eng_scl = 1'b1; eng_delay = cfg_half; eng_step = 3'd2;
            end
            3'd2: begin
                if (!sda) begin
                    end_command(ST_LOWBEFORE, 8'h00);
                end else begin
                    eng_sda = 1'b0; eng_delay = cfg_half; eng_step = 3'd3;
                end
            end
            3'd3: begin
                if (sda) begin
                    end_command(ST_HIGHAFTER, 8'h00);
                end else begin
                    eng_scl = 1'b0; eng_delay = cfg_half; eng_step = 3'd4;
                end
            end
            default: end_command(ST_OK, 8'h00);
        endcase
    endfunction

    function automatic void stop_step();
        case (eng_step)
            3'd0: begin
                eng_sda = 1'b0; eng_scl = 1'b0; eng_delay = cfg_half; eng_step = 3'd1;
            end
            3'd1: begin
                eng_scl = 1'b1; eng_delay = cfg_half; eng_step = 3'd2;
            end
            3'd2: begin
                eng_sda = 1'b1; eng_delay = cfg_half; eng_step = 3'd3;
            end
            default: end_command(ST_OK, 8'h00);
        endcase
    endfunction

    function automatic void write_step(logic sda);
        case (eng_step)
            3'd0: begin
                eng_scl   = 1'b0;
                eng_sda   = eng_shift[7];
                eng_delay = cfg_half;
                eng_step  = 3'd1;
            end
            3'd1: begin
                eng_scl   = 1'b1;
                eng_delay = cfg_half;
                eng_shift = {eng_shift[6:0], 1'b0};
                eng_bits  = eng_bits + 4'd1;
                eng_step  = (eng_bits >= 4'd8) ? 3'd2 : 3'd0;
            end
            3'd2: begin
                eng_scl = 1'b0; eng_sda = 1'b1; eng_delay = cfg_half; eng_step = 3'd3;
            end
            3'd3: begin
                eng_scl = 1'b1; eng_poll = 16'd0; eng_step = 3'd4;
            end
            3'd4: begin
                // ack window: slave pulls SDA low, or we give up after the poll limit
                if (!sda) begin
                    eng_scl = 1'b0; eng_delay = cfg_half; eng_step = 3'd5;
                end else begin
                    eng_poll = eng_poll + 16'd1;
                    if (eng_poll >= cfg_poll) begin
                        eng_nack  = 1'b1;
                        eng_scl   = 1'b0;
                        eng_delay = cfg_half;
                        eng_step  = 3'd5;
                    end
                end
            end
            default: end_command(eng_nack ? ST_NOACK : ST_OK, 8'h00);
        endcase
    endfunction

    function automatic void read_step(logic sda);
        case (eng_step)
            3'd0: begin
                eng_scl = 1'b0; eng_sda = 1'b1; eng_delay = cfg_setup; eng_step = 3'd1;
            end
            3'd1: begin
                eng_scl = 1'b1; eng_delay = cfg_half; eng_step = 3'd2;
            end
            3'd2: begin
                eng_shift = {eng_shift[6:0], sda};
                eng_scl   = 1'b0;
                eng_delay = cfg_half;
                eng_bits  = eng_bits + 4'd1;
                eng_step  = (eng_bits >= 4'd8) ? 3'd3 : 3'd1;
            end
            3'd3: begin
                eng_sda = eng_nack; eng_delay = cfg_half; eng_step = 3'd4;
            end
            3'd4: begin
                eng_scl = 1'b1; eng_delay = cfg_half; eng_step = 3'd5;
            end
            3'd5: begin
                eng_scl = 1'b0; eng_delay = cfg_half; eng_step = 3'd6;
            end
            default: end_command(ST_OK, eng_shift);
        endcase
    endfunction

    function automatic void phase_step(logic sda);
        case (eng_phase)
            PH_START: start_step(sda);
            PH_STOP:  stop_step();
            PH_WRITE: write_step(sda);
            PH_READ:  read_step(sda);
            default:  end_command(ST_OK, 8'h00);
        endcase
    endfunction

    function automatic result_t engine_tick(logic [2:0] kind, logic [7:0] tx, logic rnack,
                                            logic sda);
        bit      is_cmd;
        bit      rejected;
        result_t r;
        is_cmd      = (kind >= KIND_START) && (kind <= KIND_READ);
        rejected    = 1'b0;
        done_now    = 1'b0;
        done_status = ST_OK;
        done_rx     = 8'h00;
        if (eng_phase == PH_IDLE) begin
            if (is_cmd) begin
                eng_phase = kind;
                eng_step  = 3'd0;
                eng_bits  = 4'd0;
                eng_delay = 16'd0;
                eng_poll  = 16'd0;
                eng_nack  = 1'b0;
                if (kind == KIND_WRITE) begin
                    eng_shift = tx;
                end else if (kind == KIND_READ) begin
                    eng_shift = 8'h00;
                    eng_nack  = rnack;
                end
                phase_step(sda);
            end
        end else begin
            rejected = is_cmd;
            if (eng_delay != 16'd0) eng_delay = eng_delay - 16'd1;
            else phase_step(sda);
        end
        r.scl    = eng_scl;
        r.sda    = eng_sda;
        r.busy   = (eng_phase != PH_IDLE);
        r.done   = done_now;
        r.status = done_now ? done_status : (rejected ? ST_REJECTED : ST_OK);
        r.rx     = done_now ? done_rx : 8'h00;
        return r;
    endfunction

    // SDA as seen on the wire: our drive ANDed with a slave that mostly releases,
    // plus an occasional glitch to break start checks
    function automatic logic line_sda();
        if ($urandom_range(19) == 0) return 1'($urandom_range(1));
        return eng_sda & ($urandom_range(3) != 0);
    endfunction

    //------------------------------------------------------------------
    // Request side
    //------------------------------------------------------------------
    task automatic send_tick(logic [2:0] kind, logic [7:0] tx, logic rnack, logic sda,
                             bit typed, result_t want);
        result_t r;
        r = engine_tick(kind, tx, rnack, sda);
        pending_results.push_back(typed ? want : r);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_tx_byte   <= tx;
        s_read_nack <= rnack;
        s_sda_in    <= sda;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        ticks_sent++;
    endtask

    // tick until the running command ends; noisy mode drops in commands while busy
    task automatic finish_command(bit noisy, bit hold_high);
        logic [2:0] k;
        logic       sda;
        while (eng_phase != PH_IDLE) begin
            k = KIND_TICK;
            if (noisy && $urandom_range(99) < 8) k = 3'($urandom_range(1, 7));
            sda = hold_high ? 1'b1 : line_sda();
            send_tick(k, 8'($urandom_range(255)), 1'($urandom_range(1)), sda, 1'b0, '0);
        end
    endtask

    task automatic run_random(int n);
        int         stop_at;
        logic [2:0] k;
        stop_at = ticks_sent + n;
        while (ticks_sent < stop_at) begin
            if ($urandom_range(9) < 8) begin
                k = 3'($urandom_range(KIND_START, KIND_READ));
                send_tick(k, 8'($urandom_range(255)), 1'($urandom_range(1)), line_sda(),
                          1'b0, '0);
                finish_command(1'b1, 1'b0);
            end else begin
                // idle noise: plain tick or an unknown kind
                k = 3'($urandom_range(3));
                if (k != KIND_TICK) k = k + 3'd4;
                send_tick(k, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'b0, '0);
            end
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    //------------------------------------------------------------------
    // Register port
    //------------------------------------------------------------------
    task automatic apb_transfer(bit wr, logic [1:0] idx, logic [15:0] wdata,
                                output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, wdata};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic check_reg(logic [1:0] idx, logic [15:0] val);
        logic [31:0] rd;
        apb_transfer(1'b0, idx, 16'h0000, rd);
        if (rd[15:0] !== val) begin
            note_error($sformatf("reg %0d readback: expected %04h, got %04h", idx, val,
                                 rd[15:0]));
        end
    endtask

    task automatic set_reg(logic [1:0] idx, logic [15:0] val);
        logic [31:0] rd;
        apb_transfer(1'b1, idx, val, rd);
        case (idx)
            REG_HALF:  cfg_half  = val;
            REG_SETUP: cfg_setup = val;
            REG_POLL:  cfg_poll  = val;
            default: ;
        endcase
        check_reg(idx, val);
    endtask

    task automatic set_config(logic [15:0] half, logic [15:0] setup, logic [15:0] poll);
        wait_idle();
        set_reg(REG_HALF, half);
        set_reg(REG_SETUP, setup);
        set_reg(REG_POLL, poll);
    endtask

    function automatic void add_row(logic [2:0] kind, logic [7:0] tx, logic rnack,
                                    logic sda, bit drain, bit typed, result_t want);
        dir_row_t row;
        row.kind  = kind;
        row.tx    = tx;
        row.rnack = rnack;
        row.sda   = sda;
        row.drain = drain;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    //------------------------------------------------------------------
    // Result side
    //------------------------------------------------------------------
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_scl_release, m_sda_release, m_busy_res, m_done_res, m_status, m_rx_byte};
            if (pending_results.size() == 0) begin
                note_error({"result with no request pending: ", fmt_result(got)});
            end else begin
                want = pending_results.pop_front();
                if (got.scl !== want.scl || got.sda !== want.sda || got.busy !== want.busy
                    || got.done !== want.done || got.status !== want.status
                    || got.rx !== want.rx) begin
                    note_error({"expected ", fmt_result(want), " | got ", fmt_result(got)});
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || psel || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------
    initial begin
        dir_row_t row;
        aresetn     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = 32'h0;
        s_valid     = 1'b0;
        s_kind      = KIND_TICK;
        s_tx_byte   = 8'h00;
        s_read_nack = 1'b0;
        s_sda_in    = 1'b1;
        gap_pct     = 25;
        stall_pct   = 72;
        cfg_half    = HALF_RESET;
        cfg_setup   = SETUP_RESET;
        cfg_poll    = POLL_RESET;
        eng_phase   = PH_IDLE;
        eng_step    = 3'd0;
        eng_bits    = 4'd0;
        eng_shift   = 8'h00;
        eng_delay   = 16'd0;
        eng_poll    = 16'd0;
        eng_nack    = 1'b0;
        eng_scl     = 1'b1;
        eng_sda     = 1'b1;

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        check_reg(REG_HALF, HALF_RESET);
        check_reg(REG_SETUP, SETUP_RESET);
        check_reg(REG_POLL, POLL_RESET);

        // zero delays: every step lands on the following tick
        set_config(16'd0, 16'd0, 16'd0);

        add_row(KIND_TICK,  8'h00, 1'b0, 1'b1, 1'b0, 1'b1,
                line_result(1'b1, 1'b1, 1'b0, 1'b0, ST_OK));
        add_row(KIND_START, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0);
        add_row(KIND_TICK,  8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0);
        add_row(KIND_WRITE, 8'h5A, 1'b0, 1'b1, 1'b0, 1'b1,
                line_result(1'b1, 1'b0, 1'b1, 1'b0, ST_REJECTED));
        add_row(KIND_TICK,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(KIND_TICK,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        // start with SDA held low by someone else
        add_row(KIND_START, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(KIND_TICK,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(KIND_TICK,  8'h00, 1'b0, 1'b0, 1'b0, 1'b1,
                line_result(1'b1, 1'b1, 1'b0, 1'b1, ST_LOWBEFORE));
        // start where SDA never follows our pull-down
        add_row(KIND_START, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0);
        add_row(KIND_TICK,  8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0);
        add_row(KIND_TICK,  8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0);
        add_row(KIND_TICK,  8'h00, 1'b0, 1'b1, 1'b0, 1'b1,
                line_result(1'b1, 1'b0, 1'b0, 1'b1, ST_HIGHAFTER));
        add_row(3'd5,       8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, '0);
        add_row(KIND_STOP,  8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0);
        add_row(KIND_TICK,  8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0);
        add_row(KIND_TICK,  8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0);
        add_row(KIND_TICK,  8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0);
        add_row(3'd7,       8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0);
        add_row(KIND_WRITE, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, '0);
        add_row(KIND_READ,  8'h00, 1'b1, 1'b0, 1'b1, 1'b1,
                line_result(1'b1, 1'b1, 1'b1, 1'b0, ST_REJECTED));
        add_row(KIND_WRITE, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, '0);
        add_row(KIND_READ,  8'h00, 1'b1, 1'b1, 1'b1, 1'b0, '0);
        add_row(KIND_READ,  8'h00, 1'b0, 1'b0, 1'b1, 1'b0, '0);
        add_row(3'd6,       8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_tick(row.kind, row.tx, row.rnack, row.sda, row.typed, row.want);
            if (row.drain) finish_command(1'b0, 1'b0);
        end

        set_config(16'd1, 16'd3, 16'd4);
        run_random(PHASE_TICKS);
        set_config(16'd2, 16'd0, 16'd1);
        run_random(PHASE_TICKS);

        // receiver mostly ready, sender stalls more often
        gap_pct   = 72;
        stall_pct = 25;
        set_config(16'd0, 16'd1, 16'd2);
        run_random(PHASE_TICKS);
        set_config(16'd2, 16'd0, 16'd6);
        run_random(PHASE_TICKS);

        gap_pct   = 0;
        stall_pct = 0;
        set_config(HALF_RESET, SETUP_RESET, POLL_RESET);
        run_random(PHASE_TICKS);
        set_config(16'd1, 16'd0, 16'd0);
        run_random(PHASE_TICKS);

        // all-ones registers read back, then a long stop, a long read setup
        // and an ack poll that runs out
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        set_config(16'd20, 16'd40, 16'd60);
        send_tick(KIND_STOP, 8'h00, 1'b0, 1'b1, 1'b0, '0);
        finish_command(1'b0, 1'b0);
        set_config(16'd0, 16'd40, 16'd60);
        send_tick(KIND_READ, 8'h00, 1'b1, 1'b1, 1'b0, '0);
        finish_command(1'b0, 1'b1);
        send_tick(KIND_WRITE, 8'hC3, 1'b0, 1'b1, 1'b0, '0);
        finish_command(1'b0, 1'b1);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== i2c_master_byte_engine_unit.f =====
+incdir+src
src/i2cm_pkg.sv
src/i2cm_regs.sv
src/i2cm_step.sv
src/i2c_master_byte_engine_unit.sv
bench/tb_top.sv
